FILE: rtl/core/phmd_pkg.sv
`default_nettype none

package phmd_pkg;

  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;
  localparam int HASH_W  = 30;

  localparam logic [HASH_W-1:0]  HASH_PRIME  = 30'd1000000007;
  localparam logic [HASH_W-1:0]  HASH_RESET  = 30'd0;
  localparam logic [HASH_W-1:0]  POWER_RESET = 30'd1;
  localparam logic [8:0]         HASH_BASE   = 9'd313;
  // floor(2^39 / prime), for the quotient estimate of a 39-bit product
  localparam logic [9:0]         BARRETT_R   = 10'd549;
  // (n * DIV10_MAGIC) >> 35 == n / 10 for any 32-bit n
  localparam logic [31:0]        DIV10_MAGIC = 32'hCCCCCCCD;
  localparam logic [DIGIT_W-1:0] ASCII_ZERO  = 6'd48;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL_TERM,
    OP_MUL_POW,
    OP_QEST,
    OP_SUBQ,
    OP_FIX_TERM,
    OP_FIX_POW,
    OP_DIV_Q,
    OP_EMIT,
    OP_EMIT_EMPTY
  } phmd_op_t;

  typedef struct packed {
    phmd_op_t op;
  } phmd_cmd_t;

  typedef struct packed {
    logic has_char;
    logic end_of_string;
    logic r_ge_p;
    logic acc_zero;
    logic dq_zero;
    logic out_free;
  } phmd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/phmd_in_if.sv
`default_nettype none

interface phmd_in_if
  import phmd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              has_char;
  logic              end_of_string;

  modport source (output valid, char_code, has_char, end_of_string, input ready);
  modport sink   (input valid, char_code, has_char, end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/phmd_out_if.sv
`default_nettype none

interface phmd_out_if
  import phmd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_char;
  logic               last_digit;
  logic               empty_hash;

  modport source (output valid, digit_char, last_digit, empty_hash, input ready);
  modport sink   (input valid, digit_char, last_digit, empty_hash, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/poly_hash_mod_prime_decimal_core.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    char_code[6:0], has_char, end_of_string
// out_ch    out  valid/ready    digit_char[5:0], last_digit, empty_hash
//
// A character transaction performs two modular multiplies (weighted term, next
// power), each on the shared multiply-reduce datapath: product, quotient estimate,
// subtract, fixups until below the prime. End of string adds an end step, then a
// divide and an emit step per decimal digit (up to 10 digits), or one emit for a
// zero hash; an end without a character skips both multiplies.
// Reset (synchronous, active low) clears the hash to 0 and the power to 1.
// A stalled output register holds the digit; the digit loop waits until it drains.
`default_nettype none

module poly_hash_mod_prime_decimal_core
  import phmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  phmd_in_if.sink    in_ch,
  phmd_out_if.source out_ch
);

  phmd_cmd_t  cmd;
  phmd_stat_t stat;

  // sequencer: accept, fold character, emit digits
  phmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hash state, multiply-reduce unit, digit extraction and output register
  phmd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char_code     (in_ch.char_code),
    .in_has_char      (in_ch.has_char),
    .in_end_of_string (in_ch.end_of_string),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_digit_char   (out_ch.digit_char),
    .out_last_digit   (out_ch.last_digit),
    .out_empty_hash   (out_ch.empty_hash)
  );

endmodule

`default_nettype wire

FILE: rtl/core/phmd_ctrl.sv
`default_nettype none

module phmd_ctrl
  import phmd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire phmd_stat_t stat,
  output phmd_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_QEST,
    S_SUBQ,
    S_FIX,
    S_END,
    S_DIVQ,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t state_r, state_nxt;
  logic   pow_r, pow_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    pow_nxt   = pow_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.op = OP_LATCH;
        if (in_valid && in_ready_r) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pow_nxt = 1'b0;
        if (stat.has_char) begin
          state_nxt = S_MUL;
        end else if (stat.end_of_string) begin
          state_nxt = S_END;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.op    = pow_r ? OP_MUL_POW : OP_MUL_TERM;
        state_nxt = S_QEST;
      end
      S_QEST: begin
        cmd.op    = OP_QEST;
        state_nxt = S_SUBQ;
      end
      S_SUBQ: begin
        cmd.op    = OP_SUBQ;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.op = pow_r ? OP_FIX_POW : OP_FIX_TERM;
        if (!stat.r_ge_p) begin
          if (!pow_r) begin
            pow_nxt   = 1'b1;
            state_nxt = S_MUL;
          end else if (stat.end_of_string) begin
            state_nxt = S_END;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_END: begin
        state_nxt = stat.acc_zero ? S_EMPTY : S_DIVQ;
      end
      S_DIVQ: begin
        cmd.op    = OP_DIV_Q;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = stat.dq_zero ? S_IDLE : S_DIVQ;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pow_r      <= 1'b0;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pow_r      <= pow_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  // ready only while parked in idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == S_IDLE))
    else $error("ready raised outside idle");

  // a transaction always moves to dispatch
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready_r) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  // emit ops only issued with a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT || cmd.op == OP_EMIT_EMPTY) |-> stat.out_free)
    else $error("emit into a full output register");

endmodule

`default_nettype wire

FILE: rtl/core/phmd_dp.sv
`default_nettype none

module phmd_dp
  import phmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CHAR_W-1:0] in_char_code,
  input  wire logic              in_has_char,
  input  wire logic              in_end_of_string,
  input  wire phmd_cmd_t         cmd,
  output phmd_stat_t             stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DIGIT_W-1:0]     out_digit_char,
  output logic                   out_last_digit,
  output logic                   out_empty_hash
);

  logic [CHAR_W-1:0]  char_r;
  logic               has_char_r;
  logic               eos_r;
  logic [38:0]        prod_r;
  logic [9:0]         bq_r;
  logic [31:0]        r_r;
  logic [HASH_W-1:0]  dq_r;
  logic [HASH_W-1:0]  acc_r, acc_nxt;
  logic [HASH_W-1:0]  wp_r, wp_nxt;
  logic               out_valid_r;
  logic [DIGIT_W-1:0] digit_r;
  logic               last_r;
  logic               empty_r;

  logic [8:0]         mul_b;
  logic [38:0]        mul_p;
  logic [19:0]        bq_full;
  logic [39:0]        qp;
  logic [39:0]        diff;
  logic               r_ge_p;
  logic [30:0]        sum;
  logic [30:0]        sum_red;
  logic [61:0]        dprod;
  logic [HASH_W-1:0]  dq10;
  logic [HASH_W-1:0]  rem;
  logic               out_free;

  assign mul_b    = (cmd.op == OP_MUL_POW) ? HASH_BASE : {2'b00, char_r};
  assign mul_p    = 39'(wp_r) * 39'(mul_b);
  assign bq_full  = 20'(prod_r[38:29]) * 20'(BARRETT_R);
  assign qp       = 40'(bq_r) * 40'(HASH_PRIME);
  assign diff     = {1'b0, prod_r} - qp;
  assign r_ge_p   = (r_r >= 32'(HASH_PRIME));
  assign sum      = {1'b0, acc_r} + {1'b0, r_r[HASH_W-1:0]};
  assign sum_red  = (sum >= 31'(HASH_PRIME)) ? (sum - 31'(HASH_PRIME)) : sum;
  assign dprod    = 62'(acc_r) * 62'(DIV10_MAGIC);
  assign dq10     = {dq_r[HASH_W-4:0], 3'b000} + {dq_r[HASH_W-2:0], 1'b0};
  assign rem      = acc_r - dq10;
  assign out_free = !out_valid_r || out_ready;

  assign stat.has_char      = has_char_r;
  assign stat.end_of_string = eos_r;
  assign stat.r_ge_p        = r_ge_p;
  assign stat.acc_zero      = (acc_r == HASH_RESET);
  assign stat.dq_zero       = (dq_r == '0);
  assign stat.out_free      = out_free;

  assign out_valid      = out_valid_r;
  assign out_digit_char = digit_r;
  assign out_last_digit = last_r;
  assign out_empty_hash = empty_r;

  always_comb begin
    acc_nxt = acc_r;
    wp_nxt  = wp_r;
    case (cmd.op)
      OP_FIX_TERM: begin
        if (!r_ge_p) begin
          acc_nxt = sum_red[HASH_W-1:0];
        end
      end
      OP_FIX_POW: begin
        if (!r_ge_p) begin
          wp_nxt = r_r[HASH_W-1:0];
        end
      end
      OP_EMIT: begin
        acc_nxt = dq_r;
        if (dq_r == '0) begin
          wp_nxt = POWER_RESET;
        end
      end
      OP_EMIT_EMPTY: begin
        acc_nxt = HASH_RESET;
        wp_nxt  = POWER_RESET;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= HASH_RESET;
      wp_r        <= POWER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      wp_r  <= wp_nxt;
      if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_EMPTY) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        char_r     <= in_char_code;
        has_char_r <= in_has_char;
        eos_r      <= in_end_of_string;
      end
      OP_MUL_TERM, OP_MUL_POW: begin
        prod_r <= mul_p;
      end
      OP_QEST: begin
        bq_r <= bq_full[19:10];
      end
      OP_SUBQ: begin
        r_r <= diff[31:0];
      end
      OP_FIX_TERM, OP_FIX_POW: begin
        if (r_ge_p) begin
          r_r <= r_r - 32'(HASH_PRIME);
        end
      end
      OP_DIV_Q: begin
        dq_r <= {3'b000, dprod[61:35]};
      end
      OP_EMIT: begin
        digit_r <= ASCII_ZERO + {2'b00, rem[3:0]};
        last_r  <= (dq_r == '0);
        empty_r <= 1'b0;
      end
      OP_EMIT_EMPTY: begin
        digit_r <= ASCII_ZERO;
        last_r  <= 1'b1;
        empty_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < HASH_PRIME)
    else $error("hash accumulator out of range");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r < HASH_PRIME) && (wp_r != '0))
    else $error("weight power out of range");

  // the final digit of a run leaves both registers at their reset values
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_EMIT && dq_r == '0) || cmd.op == OP_EMIT_EMPTY)
      |=> (acc_r == HASH_RESET) && (wp_r == POWER_RESET))
    else $error("state not cleared after digit run");

endmodule

`default_nettype wire
